// ----- sv/vtp_pkg.sv -----
// vtp_pkg: shared constants and types for the vertex transform and projection block.
// Used by every module of the block; depends on nothing.
package vtp_pkg;

  // Fixed-point format of the matrix coefficients
  localparam int FRAC_BITS  = 14;
  localparam int PRE_SHIFT  = 2;
  localparam int FRAC_SHIFT = FRAC_BITS - PRE_SHIFT;

  // Field widths
  localparam int POS_W   = 16;
  localparam int COORD_W = 32;
  localparam int COEF_W  = 32 - PRE_SHIFT;
  localparam int PROD_W  = POS_W + COEF_W;
  localparam int DIST_W  = 16;
  localparam int NUM_W   = COORD_W + DIST_W;

  // Divider: one quotient bit per stage
  localparam int DIV_STEPS = COORD_W;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration port
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ROW0_AB      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_CT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_AB      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_CT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_AB      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_CT      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_DIST    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_CENTRE  = 3'd7;

  localparam logic [31:0] VIEW_DIST_RESET = 32'h0001_0001;

  typedef struct packed {
    logic [2:0][63:0] ab;
    logic [2:0][63:0] ct;
  } xform_cfg_t;

  typedef struct packed {
    logic [31:0] distance;
    logic [31:0] centre;
  } proj_cfg_t;

  // One transformed vertex as it waits between front and back
  typedef struct packed {
    logic [COORD_W-1:0] vx;
    logic [COORD_W-1:0] vy;
    logic [COORD_W-1:0] vz;
    logic               le0;  // depth at or behind the eye plane: project
  } view_item_t;

  // Per-lane side data that rides along with a division
  typedef struct packed {
    logic               neg;
    logic [COORD_W-1:0] coord;
  } div_tag_t;

endpackage

// ----- sv/vtp_front.sv -----
// vtp_front: accepts vertices, applies the 3x4 matrix and classifies the depth.
// Depends on vtp_pkg.
module vtp_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  output logic                     full,
  input  logic signed [15:0]       pos_x,
  input  logic signed [15:0]       pos_y,
  input  logic signed [15:0]       pos_z,
  input  vtp_pkg::xform_cfg_t      xcfg,
  input  logic                     q_full,
  output logic                     q_push,
  output vtp_pkg::view_item_t      q_data
);
  import vtp_pkg::*;

  logic fadv;

  logic                     f1_v_r;
  logic signed [POS_W-1:0]  f1_pos_r [3];
  logic                     f2_v_r;
  logic signed [PROD_W-1:0] f2_prod_r [3][3];
  logic                     f3_v_r;
  view_item_t               f3_item_r;

  logic signed [COEF_W-1:0] coef [3][3];
  logic signed [PROD_W-1:0] prod_nxt [3][3];
  view_item_t               item_nxt;

  // Whole front stalls only when its last stage cannot enter the queue
  assign fadv   = !(f3_v_r && q_full);
  assign full   = !fadv;
  assign q_push = f3_v_r && !q_full;
  assign q_data = f3_item_r;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      coef[r][0] = xcfg.ab[r][31:PRE_SHIFT];
      coef[r][1] = xcfg.ab[r][63:32+PRE_SHIFT];
      coef[r][2] = xcfg.ct[r][31:PRE_SHIFT];
      for (int k = 0; k < 3; k++) begin
        prod_nxt[r][k] = f1_pos_r[k] * coef[r][k];
      end
    end
  end

  always_comb begin : sum_blk
    logic signed [PROD_W-1:0] sh;
    logic [COORD_W-1:0]       acc [3];
    for (int r = 0; r < 3; r++) begin
      acc[r] = xcfg.ct[r][63:32];
      for (int k = 0; k < 3; k++) begin
        sh     = f2_prod_r[r][k] >>> FRAC_SHIFT;
        acc[r] = acc[r] + COORD_W'(sh);
      end
    end
    item_nxt.vx  = acc[0];
    item_nxt.vy  = acc[1];
    item_nxt.vz  = acc[2];
    item_nxt.le0 = acc[2][COORD_W-1] || (acc[2] == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
    end else if (fadv) begin
      f1_v_r <= push;
      f2_v_r <= f1_v_r;
      f3_v_r <= f2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fadv) begin
      f1_pos_r[0] <= pos_x;
      f1_pos_r[1] <= pos_y;
      f1_pos_r[2] <= pos_z;
      f2_prod_r   <= prod_nxt;
      f3_item_r   <= item_nxt;
    end
  end

endmodule

// ----- sv/vtp_queue.sv -----
// vtp_queue: short register queue of transformed vertices between front and back.
// Depends on vtp_pkg.
module vtp_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_en,
  input  vtp_pkg::view_item_t  push_data,
  output logic                 full,
  input  logic                 pop_en,
  output vtp_pkg::view_item_t  head,
  output logic                 empty
);
  import vtp_pkg::*;

  view_item_t          slot_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;

  assign full  = (count_r == QCNT_W'(QDEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_en) begin
        wr_ptr_r <= QPTR_W'(wr_ptr_r + 1'b1);
      end
      if (pop_en) begin
        rd_ptr_r <= QPTR_W'(rd_ptr_r + 1'b1);
      end
      if (push_en && !pop_en) begin
        count_r <= QCNT_W'(count_r + 1'b1);
      end else if (pop_en && !push_en) begin
        count_r <= QCNT_W'(count_r - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- sv/vtp_div.sv -----
// vtp_div: pipelined unsigned divider lane, one restoring step per stage.
// Depends on vtp_pkg. Quotient must fit in COORD_W bits.
module vtp_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [vtp_pkg::NUM_W-1:0]     dividend,
  input  logic [vtp_pkg::COORD_W-1:0]   divisor,
  input  vtp_pkg::div_tag_t             tag_in,
  output logic [vtp_pkg::COORD_W-1:0]   quot,
  output vtp_pkg::div_tag_t             tag_out
);
  import vtp_pkg::*;

  logic [COORD_W-1:0] rem_r [DIV_STEPS];
  logic [COORD_W-1:0] dq_r  [DIV_STEPS];
  logic [COORD_W-1:0] den_r [DIV_STEPS];
  div_tag_t           tag_r [DIV_STEPS];

  logic [COORD_W-1:0] rem_in [DIV_STEPS];
  logic [COORD_W-1:0] dq_in  [DIV_STEPS];
  logic [COORD_W-1:0] den_in [DIV_STEPS];
  div_tag_t           tag_i  [DIV_STEPS];

  logic [COORD_W-1:0] rem_nxt [DIV_STEPS];
  logic [COORD_W-1:0] dq_nxt  [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_link
    if (k == 0) begin : g_first
      // high part of the dividend is already below the divisor
      assign rem_in[k] = COORD_W'(dividend[NUM_W-1:COORD_W]);
      assign dq_in[k]  = dividend[COORD_W-1:0];
      assign den_in[k] = divisor;
      assign tag_i[k]  = tag_in;
    end else begin : g_next
      assign rem_in[k] = rem_r[k-1];
      assign dq_in[k]  = dq_r[k-1];
      assign den_in[k] = den_r[k-1];
      assign tag_i[k]  = tag_r[k-1];
    end
  end

  always_comb begin : step_blk
    logic [COORD_W:0] trial;
    logic [COORD_W:0] diff;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial = {rem_in[k], dq_in[k][COORD_W-1]};
      diff  = trial - {1'b0, den_in[k]};
      if (trial >= {1'b0, den_in[k]}) begin
        rem_nxt[k] = diff[COORD_W-1:0];
        dq_nxt[k]  = {dq_in[k][COORD_W-2:0], 1'b1};
      end else begin
        rem_nxt[k] = trial[COORD_W-1:0];
        dq_nxt[k]  = {dq_in[k][COORD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        rem_r[k] <= rem_nxt[k];
        dq_r[k]  <= dq_nxt[k];
        den_r[k] <= den_in[k];
        tag_r[k] <= tag_i[k];
      end
    end
  end

  assign quot    = dq_r[DIV_STEPS-1];
  assign tag_out = tag_r[DIV_STEPS-1];

endmodule

// ----- sv/vtp_back.sv -----
// vtp_back: perspective projection of queued vertices and the result register.
// Depends on vtp_pkg and vtp_div.
module vtp_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  output logic                         q_pop,
  input  vtp_pkg::view_item_t          q_head,
  input  vtp_pkg::proj_cfg_t           pcfg,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [31:0]           screen_x,
  output logic signed [31:0]           screen_y,
  output logic signed [31:0]           view_depth
);
  import vtp_pkg::*;

  logic badv;

  // projection setup stage
  logic               b0_v_r;
  logic               b0_le0_r;
  logic [COORD_W-1:0] b0_vz_r;
  logic [NUM_W-1:0]   b0_num_r [2];
  logic [COORD_W-1:0] b0_den_r [2];
  div_tag_t           b0_tag_r [2];

  logic [NUM_W-1:0]   num_nxt [2];
  logic [COORD_W-1:0] den_nxt [2];
  div_tag_t           tag_nxt [2];

  // side line alongside the divider stages
  logic               side_v_r   [DIV_STEPS];
  logic               side_le0_r [DIV_STEPS];
  logic [COORD_W-1:0] side_vz_r  [DIV_STEPS];

  logic [COORD_W-1:0] quot [2];
  div_tag_t           tag_o [2];
  logic [COORD_W-1:0] res_nxt [2];

  logic               out_v_r;
  logic [COORD_W-1:0] out_x_r;
  logic [COORD_W-1:0] out_y_r;
  logic [COORD_W-1:0] out_z_r;

  assign badv  = !out_v_r || pop;
  assign q_pop = badv && !q_empty;

  always_comb begin : setup_blk
    logic [COORD_W:0]   cs;
    logic [COORD_W:0]   mag;
    logic [DIST_W-1:0]  dist_half;
    logic [COORD_W-1:0] negz;
    negz = COORD_W'(0) - q_head.vz;
    for (int l = 0; l < 2; l++) begin
      if (l == 0) begin
        cs = {q_head.vx[COORD_W-1], q_head.vx};
      end else begin
        cs = (COORD_W+1)'(0) - {q_head.vy[COORD_W-1], q_head.vy};
      end
      mag       = cs[COORD_W] ? (COORD_W+1)'(0) - cs : cs;
      dist_half = pcfg.distance[l*DIST_W +: DIST_W];
      if (dist_half == '0) begin
        dist_half = DIST_W'(1);
      end
      num_nxt[l]       = mag[COORD_W-1:0] * dist_half;
      den_nxt[l]       = COORD_W'(dist_half) + negz;
      tag_nxt[l].neg   = cs[COORD_W];
      tag_nxt[l].coord = cs[COORD_W-1:0];
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    vtp_div u_div (
      .clk      (clk),
      .en       (badv),
      .dividend (b0_num_r[l]),
      .divisor  (b0_den_r[l]),
      .tag_in   (b0_tag_r[l]),
      .quot     (quot[l]),
      .tag_out  (tag_o[l])
    );
  end

  always_comb begin : final_blk
    logic [COORD_W-1:0] sq;
    logic [COORD_W-1:0] cen;
    for (int l = 0; l < 2; l++) begin
      cen = COORD_W'(signed'(pcfg.centre[l*DIST_W +: DIST_W]));
      sq  = tag_o[l].neg ? COORD_W'(0) - quot[l] : quot[l];
      if (side_le0_r[DIV_STEPS-1]) begin
        res_nxt[l] = sq + cen;
      end else begin
        res_nxt[l] = tag_o[l].coord + cen;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      for (int k = 0; k < DIV_STEPS; k++) begin
        side_v_r[k] <= 1'b0;
      end
    end else if (badv) begin
      b0_v_r      <= q_pop;
      side_v_r[0] <= b0_v_r;
      for (int k = 1; k < DIV_STEPS; k++) begin
        side_v_r[k] <= side_v_r[k-1];
      end
      out_v_r <= side_v_r[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (badv) begin
      b0_le0_r      <= q_head.le0;
      b0_vz_r       <= q_head.vz;
      b0_num_r      <= num_nxt;
      b0_den_r      <= den_nxt;
      b0_tag_r      <= tag_nxt;
      side_le0_r[0] <= b0_le0_r;
      side_vz_r[0]  <= b0_vz_r;
      for (int k = 1; k < DIV_STEPS; k++) begin
        side_le0_r[k] <= side_le0_r[k-1];
        side_vz_r[k]  <= side_vz_r[k-1];
      end
      out_x_r <= res_nxt[0];
      out_y_r <= res_nxt[1];
      out_z_r <= side_vz_r[DIV_STEPS-1];
    end
  end

  assign empty      = !out_v_r;
  assign screen_x   = out_x_r;
  assign screen_y   = out_y_r;
  assign view_depth = out_z_r;

endmodule

// ----- sv/vertex_transform_project.sv -----
// vertex_transform_project: top level of the fixed-point vertex transform and projection.
// Depends on vtp_pkg, vtp_front, vtp_queue, vtp_back and vtp_div.
//
// Use:
//   Vertices enter on a queue-style port: a request (in_pos_x/y/z) is taken at a
//   rising edge with push high and full low. Results leave the same way: while
//   empty is low the oldest result sits on out_screen_x/y and out_view_depth,
//   and it is taken at an edge with pop high.
//   The matrix rows, view distances and screen centre live in an APB register
//   file (64-bit data, register i at byte address 8*i); write them while idle.
// Timing:
//   One vertex per clock sustained while the receiver does not hold off pop. An
//   accepted vertex passes through 3 front stages (input, multiply, row sums),
//   a queue slot, 1 projection setup stage, 32 divider stages (one quotient bit
//   each) and the result register. The divider pipeline sets the latency.
// Flow control:
//   When the receiver holds off pop, the back end freezes in place, the
//   4-entry queue absorbs the front end's work and full rises once the queue
//   is full and a vertex waits in the last front stage. Nothing is dropped or
//   repeated.
// Reset:
//   rst_n (synchronous, active low) empties the pipeline and queue, clears the
//   matrix and centre and sets both view distances to 1.
module vertex_transform_project (
  input  logic                            clk,
  input  logic                            rst_n,
  // vertex input
  input  logic                            push,
  output logic                            full,
  input  logic signed [15:0]              in_pos_x,
  input  logic signed [15:0]              in_pos_y,
  input  logic signed [15:0]              in_pos_z,
  // result output
  output logic                            empty,
  input  logic                            pop,
  output logic signed [31:0]              out_screen_x,
  output logic signed [31:0]              out_screen_y,
  output logic signed [31:0]              out_view_depth,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vtp_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [vtp_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [vtp_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import vtp_pkg::*;

  // Register file
  logic [63:0] row_ab_r [3];
  logic [63:0] row_ct_r [3];
  logic [31:0] view_dist_r;
  logic [31:0] view_centre_r;

  logic                 cfg_wr;
  logic [CFG_IDX_W-1:0] cfg_idx;

  xform_cfg_t xcfg;
  proj_cfg_t  pcfg;

  // Front/queue/back glue
  logic       q_push;
  logic       q_full;
  view_item_t q_data;
  logic       q_pop;
  logic       q_empty;
  view_item_t q_head;

  // Every access completes in its access cycle
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[CFG_ADDR_W-1:CFG_ADDR_W-CFG_IDX_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        row_ab_r[r] <= '0;
        row_ct_r[r] <= '0;
      end
      view_dist_r   <= VIEW_DIST_RESET;
      view_centre_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ROW0_AB:     row_ab_r[0]   <= pwdata;
        REG_ROW0_CT:     row_ct_r[0]   <= pwdata;
        REG_ROW1_AB:     row_ab_r[1]   <= pwdata;
        REG_ROW1_CT:     row_ct_r[1]   <= pwdata;
        REG_ROW2_AB:     row_ab_r[2]   <= pwdata;
        REG_ROW2_CT:     row_ct_r[2]   <= pwdata;
        REG_VIEW_DIST:   view_dist_r   <= pwdata[31:0];
        REG_VIEW_CENTRE: view_centre_r <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register; 32-bit registers read zero-extended
  always_comb begin
    unique case (cfg_idx)
      REG_ROW0_AB:     prdata = row_ab_r[0];
      REG_ROW0_CT:     prdata = row_ct_r[0];
      REG_ROW1_AB:     prdata = row_ab_r[1];
      REG_ROW1_CT:     prdata = row_ct_r[1];
      REG_ROW2_AB:     prdata = row_ab_r[2];
      REG_ROW2_CT:     prdata = row_ct_r[2];
      REG_VIEW_DIST:   prdata = CFG_DATA_W'(view_dist_r);
      REG_VIEW_CENTRE: prdata = CFG_DATA_W'(view_centre_r);
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      xcfg.ab[r] = row_ab_r[r];
      xcfg.ct[r] = row_ct_r[r];
    end
    pcfg.distance = view_dist_r;
    pcfg.centre   = view_centre_r;
  end

  // Front: accept, transform, classify depth
  vtp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .pos_x  (in_pos_x),
    .pos_y  (in_pos_y),
    .pos_z  (in_pos_z),
    .xcfg   (xcfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_data)
  );

  // Decouple the two halves so each can stall on its own
  vtp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop_en    (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // Back: divide, add centre, hold the result for the receiver
  vtp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_head     (q_head),
    .pcfg       (pcfg),
    .empty      (empty),
    .pop        (pop),
    .screen_x   (out_screen_x),
    .screen_y   (out_screen_y),
    .view_depth (out_view_depth)
  );

endmodule
